>>> sv/cbs_pkg.sv
package cbs_pkg;

	localparam int COORD_W = 10;
	localparam int ROWS_W = 11;
	localparam int STACK_DEPTH_DEFAULT = 128;
	localparam logic [ROWS_W-1:0] ROWS_RESET = 11'd240;
	localparam int ENTRY_W = 2 * COORD_W;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef struct packed {
		logic               command;
		logic               white;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
	} in_item_t;

	typedef struct packed {
		logic [COORD_W-1:0] point_x;
		logic [COORD_W-1:0] point_y;
		logic               is_lower;
		logic               stack_empty;
		logic               overflowed;
	} out_item_t;

endpackage

>>> sv/column_boundary_scanner_core.sv
// Column boundary scanner.
// Items enter on item/item_valid/item_ready. A pixel item (command pixel) carries one
// binary pixel of a column, top row first; a drain item pops one stored lower point.
// Results leave on result/result_valid/result_ready: an upper point for the first white
// pixel of a column, and one result for every drain item. Other pixel items give none.
// cfg_we with cfg_data sets the number of rows per column; write it only while idle.
// An accepted item passes the read stage, where the stack memory is read, and then the
// output register before result_valid rises. One item is taken per cycle while the
// receiver keeps up. The exception is a column's last row that pushes both the held
// lower point and the last row: the stack memory has one write port, so item_ready
// drops for one cycle to write the second entry.
// When the receiver stalls, one result waits in the output register and one more in the
// read stage; item_ready falls once both are occupied.
// Reset clears the flags, the stack count and the sticky overflow flag and sets the row
// count to 240. The stack memory needs no clearing; only written entries are ever read.
// A push to a full stack is dropped and sets the overflow flag.
module column_boundary_scanner_core #(
	parameter int STACK_DEPTH = cbs_pkg::STACK_DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cbs_pkg::ROWS_W-1:0]    cfg_data,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  cbs_pkg::in_item_t             item,
	output logic                          result_valid,
	input  logic                          result_ready,
	output cbs_pkg::out_item_t            result
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int XW = cbs_pkg::COORD_W;
	localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

	logic [cbs_pkg::ROWS_W-1:0] image_rows_q;
	logic                       upper_found_q;
	logic                       lower_found_q;
	logic                       held_valid_q;
	logic [XW-1:0]              held_row_q;
	logic [CW-1:0]              count_q;
	logic                       overflow_q;
	logic                       busy_q;
	logic [cbs_pkg::ENTRY_W-1:0] pend_entry_q;

	logic                       valid_s1;
	logic                       pop_s1;
	cbs_pkg::out_item_t         item_s1;
	cbs_pkg::out_item_t         result_q;
	logic                       result_valid_q;
	cbs_pkg::out_item_t         next_result;

	logic                       accept;
	logic                       pix;
	logic                       drn;
	logic                       s1_adv;
	logic                       uf0, lf0, hv0;
	logic                       uf_n, lf_n, hv_n;
	logic [XW-1:0]              hr_n;
	logic                       upper_hit;
	logic                       last_row;
	logic                       push1, push2;
	logic                       full;
	logic                       stack_empty;
	logic                       push_now;
	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	logic [cbs_pkg::ENTRY_W-1:0] wr_data;
	logic                       rd_en;
	logic [CW-1:0]              pop_count;
	logic [cbs_pkg::ENTRY_W-1:0] rd_data;
	logic [cbs_pkg::ROWS_W-1:0] last_row_idx;
	logic                       ovf_now;

	assign full = (count_q == FULL_COUNT);
	assign stack_empty = (count_q == '0);
	assign pop_count = count_q - CW'(1);

	assign s1_adv = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !busy_q && (!valid_s1 || s1_adv);
	assign accept = item_valid && item_ready;
	assign pix = accept && (item.command == cbs_pkg::CMD_PIXEL);
	assign drn = accept && (item.command == cbs_pkg::CMD_DRAIN);

	assign last_row_idx = image_rows_q - cbs_pkg::ROWS_W'(1);

	always_comb begin
		uf0 = upper_found_q;
		lf0 = lower_found_q;
		hv0 = held_valid_q;
		if (item.row == '0) begin
			uf0 = 1'b0;
			lf0 = 1'b0;
			hv0 = 1'b0;
		end
		uf_n = uf0;
		lf_n = lf0;
		hv_n = hv0;
		hr_n = held_row_q;
		upper_hit = 1'b0;
		if (item.white && !uf0) begin
			uf_n = 1'b1;
			upper_hit = 1'b1;
		end else if (!item.white && uf0 && !lf0) begin
			hr_n = item.row;
			hv_n = 1'b1;
			lf_n = 1'b1;
		end else if (lf0 && item.white) begin
			lf_n = 1'b0;
		end
		last_row = ({1'b0, item.row} == last_row_idx);
		push1 = last_row && hv_n;
		push2 = last_row && uf_n && !lf_n;
	end

	assign push_now = pix && (push1 || push2);
	assign ovf_now = overflow_q || (push_now && full);

	always_comb begin
		wr_en = 1'b0;
		wr_data = pend_entry_q;
		if (busy_q) begin
			wr_en = !full;
		end else if (push_now) begin
			wr_en = !full;
			wr_data = {item.column, (push1 ? hr_n : item.row)};
		end
		wr_addr = count_q[AW-1:0];
	end

	assign rd_en = drn && !stack_empty;

	cbs_ram #(
		.WIDTH(cbs_pkg::ENTRY_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(pop_count[AW-1:0]),
		.rdata(rd_data)
	);

	always_comb begin
		next_result = item_s1;
		if (pop_s1) begin
			next_result.point_x = rd_data[cbs_pkg::ENTRY_W-1:XW];
			next_result.point_y = rd_data[XW-1:0];
			next_result.is_lower = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_rows_q <= cbs_pkg::ROWS_RESET;
			upper_found_q <= 1'b0;
			lower_found_q <= 1'b0;
			held_valid_q <= 1'b0;
			held_row_q <= '0;
			count_q <= '0;
			overflow_q <= 1'b0;
			busy_q <= 1'b0;
			valid_s1 <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				image_rows_q <= cfg_data;
			end
			if (pix) begin
				upper_found_q <= uf_n;
				lower_found_q <= lf_n;
				held_valid_q <= hv_n;
				held_row_q <= hr_n;
			end
			if (busy_q) begin
				busy_q <= 1'b0;
				if (full) begin
					overflow_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end else if (push_now) begin
				busy_q <= push1 && push2;
				overflow_q <= ovf_now;
				if (!full) begin
					count_q <= count_q + CW'(1);
				end
			end else if (rd_en) begin
				count_q <= pop_count;
			end
			if (accept && (drn || upper_hit)) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_now && push1 && push2) begin
			pend_entry_q <= {item.column, item.row};
		end
		if (accept) begin
			pop_s1 <= drn && !stack_empty;
			if (drn) begin
				item_s1 <= '{point_x: '0, point_y: '0, is_lower: 1'b0,
					stack_empty: stack_empty, overflowed: overflow_q};
			end else begin
				item_s1 <= '{point_x: item.column, point_y: item.row, is_lower: 1'b0,
					stack_empty: 1'b0, overflowed: ovf_now};
			end
		end
		if (s1_adv) begin
			result_q <= next_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

>>> sv/cbs_ram.sv
module cbs_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> dv/column_boundary_scanner_core_test.sv
module column_boundary_scanner_core_test;

	typedef enum logic [1:0] {
		FLOW_FREE,
		FLOW_SRC_GAPS,
		FLOW_SINK_STALLS,
		FLOW_BOTH
	} flow_mode_t;

	localparam int COORD_W = cbs_pkg::COORD_W;
	localparam int ROWS_W = cbs_pkg::ROWS_W;
	localparam int ENTRY_W = cbs_pkg::ENTRY_W;
	localparam int STACK_DEPTH_DEFAULT = cbs_pkg::STACK_DEPTH_DEFAULT;
	localparam logic [ROWS_W-1:0] ROWS_RESET = cbs_pkg::ROWS_RESET;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [ROWS_W-1:0] cfg_data = '0;
	logic item_valid = 1'b0;
	logic item_ready;
	cbs_pkg::in_item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	cbs_pkg::out_item_t result;

	cbs_pkg::in_item_t scan_queue[$];
	cbs_pkg::out_item_t points_due[$];
	cbs_pkg::out_item_t next_point;
	cbs_pkg::out_item_t due_point;

	flow_mode_t flow = FLOW_FREE;
	bit hold_req = 1'b0;
	bit hold_seen = 1'b0;
	int hold_left = 0;
	int stall_cycles = 0;
	int fails = 0;

	logic [ROWS_W-1:0] rows_per_col = ROWS_RESET;
	bit upper_seen = 1'b0;
	bit lower_open = 1'b0;
	bit held_ok = 1'b0;
	logic [COORD_W-1:0] held_y = '0;
	logic [ENTRY_W-1:0] lower_stack [STACK_DEPTH_DEFAULT];
	int stack_fill = 0;
	bit ovf_sticky = 1'b0;

	column_boundary_scanner_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void stash_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		if (stack_fill >= STACK_DEPTH_DEFAULT) begin
			ovf_sticky = 1'b1;
		end else begin
			lower_stack[stack_fill] = {x, y};
			stack_fill++;
		end
	endfunction

	function automatic bit scan_boundary(input cbs_pkg::in_item_t it,
			output cbs_pkg::out_item_t pt);
		logic [ROWS_W-1:0] last_y;
		logic [ENTRY_W-1:0] entry;
		bit emits;
		pt = '0;
		emits = 1'b0;
		if (it.command == cbs_pkg::CMD_DRAIN) begin
			if (stack_fill > 0) begin
				stack_fill--;
				entry = lower_stack[stack_fill];
				pt.point_x = entry[ENTRY_W-1:COORD_W];
				pt.point_y = entry[COORD_W-1:0];
				pt.is_lower = 1'b1;
			end else begin
				pt.stack_empty = 1'b1;
			end
			pt.overflowed = ovf_sticky;
			return 1'b1;
		end
		if (it.row == '0) begin
			upper_seen = 1'b0;
			lower_open = 1'b0;
			held_ok = 1'b0;
		end
		if (it.white && !upper_seen) begin
			upper_seen = 1'b1;
			pt.point_x = it.column;
			pt.point_y = it.row;
			emits = 1'b1;
		end else if (!it.white && upper_seen && !lower_open) begin
			held_y = it.row;
			held_ok = 1'b1;
			lower_open = 1'b1;
		end else if (lower_open && it.white) begin
			lower_open = 1'b0;
		end
		last_y = rows_per_col - 1'b1;
		if ({1'b0, it.row} == last_y) begin
			if (held_ok)
				stash_point(it.column, held_y);
			if (upper_seen && !lower_open)
				stash_point(it.column, last_y[COORD_W-1:0]);
		end
		pt.overflowed = ovf_sticky;
		return emits;
	endfunction

	function automatic int src_gap_pct(input flow_mode_t m);
		case (m)
			FLOW_SRC_GAPS: return 71;
			FLOW_BOTH: return 21;
			default: return 0;
		endcase
	endfunction

	function automatic int sink_stall_pct(input flow_mode_t m);
		case (m)
			FLOW_SINK_STALLS: return 71;
			FLOW_BOTH: return 21;
			default: return 0;
		endcase
	endfunction

	function automatic void add_pixel(input logic w, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y);
		cbs_pkg::in_item_t it;
		it.command = cbs_pkg::CMD_PIXEL;
		it.white = w;
		it.column = x;
		it.row = y;
		scan_queue.push_back(it);
	endfunction

	function automatic void add_drain();
		cbs_pkg::in_item_t it;
		it.command = cbs_pkg::CMD_DRAIN;
		it.white = 1'($urandom_range(1));
		it.column = COORD_W'($urandom_range(1023));
		it.row = COORD_W'($urandom_range(1023));
		scan_queue.push_back(it);
	endfunction

	function automatic void add_noise();
		cbs_pkg::in_item_t it;
		it.command = 1'($urandom_range(1));
		it.white = 1'($urandom_range(1));
		it.column = COORD_W'($urandom_range(1023));
		it.row = COORD_W'($urandom_range(1023));
		scan_queue.push_back(it);
	endfunction

	function automatic void add_column(input int n);
		int r;
		int last;
		int flip;
		logic w;
		logic [COORD_W-1:0] x;
		x = COORD_W'($urandom_range(1023));
		w = 1'($urandom_range(1));
		case ($urandom_range(2))
			0: flip = 5;
			1: flip = 30;
			default: flip = 60;
		endcase
		last = (n == 0 || n > 1024) ? 1023 : n - 1;
		r = 0;
		while (1) begin
			add_pixel(w, x, COORD_W'(r));
			if (r >= last || (r > 0 && $urandom_range(99) < 4))
				break;
			if ($urandom_range(99) < 3)
				add_drain();
			if ($urandom_range(99) < 3)
				x = COORD_W'($urandom_range(1023));
			if ($urandom_range(99) < flip)
				w = ~w;
			r = (last <= 24) ? r + 1 : r + $urandom_range(1, last / 8 + 1);
			if (r > last)
				r = last;
		end
		if (last < 1023 && $urandom_range(99) < 5)
			add_pixel(1'($urandom_range(1)), x, COORD_W'($urandom_range(last + 1, 1023)));
	endfunction

	function automatic void add_random_unit(input int n);
		int roll;
		int k;
		roll = $urandom_range(99);
		if (roll < 12) begin
			add_noise();
		end else if (roll < 22) begin
			k = $urandom_range(1, 4);
			repeat (k) add_drain();
		end else begin
			add_column(n);
			k = $urandom_range(0, 2);
			repeat (k) add_drain();
		end
	endfunction

	task automatic log_mismatch(input string msg);
		fails++;
		if (fails <= 10)
			$display("%s", msg);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (scan_queue.size() != 0 || item_valid || points_due.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_rows(input logic [ROWS_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		rows_per_col = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
		end else begin
			if (item_valid && item_ready) begin
				if (scan_boundary(item, next_point))
					points_due.push_back(next_point);
			end
			if (!item_valid || item_ready) begin
				if (scan_queue.size() != 0 && $urandom_range(99) >= src_gap_pct(flow)) begin
					item <= scan_queue.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			hold_seen <= 1'b0;
			hold_left <= 0;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			result_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= sink_stall_pct(flow));
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (points_due.size() == 0) begin
				log_mismatch($sformatf("unexpected result: x=%0d y=%0d lower=%0b empty=%0b ovf=%0b",
					result.point_x, result.point_y, result.is_lower, result.stack_empty,
					result.overflowed));
			end else begin
				due_point = points_due.pop_front();
				if (result.point_x !== due_point.point_x || result.point_y !== due_point.point_y
						|| result.is_lower !== due_point.is_lower
						|| result.stack_empty !== due_point.stack_empty
						|| result.overflowed !== due_point.overflowed) begin
					log_mismatch($sformatf({"mismatch: expected x=%0d y=%0d lower=%0b empty=%0b ",
						"ovf=%0b, got x=%0d y=%0d lower=%0b empty=%0b ovf=%0b"},
						due_point.point_x, due_point.point_y, due_point.is_lower,
						due_point.stack_empty, due_point.overflowed, result.point_x,
						result.point_y, result.is_lower, result.stack_empty, result.overflowed));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready)
				|| (scan_queue.size() == 0 && !item_valid && points_due.size() == 0)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", stall_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		int ph;
		int rows_now;
		logic [COORD_W-1:0] x;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default row count: empty drain, black start, held lower point, double push.
		add_drain();
		add_pixel(1'b0, 10'd1023, 10'd0);
		add_pixel(1'b1, 10'd1023, 10'd1);
		add_pixel(1'b0, 10'd1023, 10'd5);
		add_pixel(1'b1, 10'd1023, 10'd6);
		add_pixel(1'b1, 10'd1023, 10'd239);
		repeat (3) add_drain();
		wait_drained();

		set_rows(11'd1024);
		add_pixel(1'b1, 10'd0, 10'd0);
		add_pixel(1'b0, 10'd0, 10'd1023);
		add_pixel(1'b1, 10'd512, 10'd1023);
		repeat (3) add_drain();
		wait_drained();

		// A two-row column, then a row past the last one.
		set_rows(11'd2);
		add_pixel(1'b1, 10'd7, 10'd0);
		add_pixel(1'b0, 10'd7, 10'd1);
		add_pixel(1'b1, 10'd7, 10'd700);
		add_drain();
		wait_drained();

		// A single row both starts and ends a column.
		set_rows(11'd1);
		add_pixel(1'b1, 10'd3, 10'd0);
		add_drain();
		wait_drained();

		// With zero or an oversized row count no column ever ends.
		set_rows(11'd0);
		add_pixel(1'b1, 10'd9, 10'd0);
		add_pixel(1'b0, 10'd9, 10'd1023);
		add_drain();
		wait_drained();

		set_rows(11'd2047);
		add_pixel(1'b1, 10'd1, 10'd0);
		add_pixel(1'b0, 10'd1, 10'd1023);
		add_drain();
		wait_drained();

		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				0: rows_now = 2;
				1: rows_now = 3;
				2: rows_now = 1024;
				3: rows_now = $urandom_range(4, 24);
				4: rows_now = 240;
				5: rows_now = $urandom_range(25, 400);
				6: rows_now = 5;
				default: rows_now = $urandom_range(2, 12);
			endcase
			set_rows(ROWS_W'(rows_now));
			flow = flow_mode_t'(ph % 4);
			if (ph == 4)
				hold_req = ~hold_req;
			while (scan_queue.size() < 180)
				add_random_unit(rows_now);
			wait_drained();
		end

		// Fill the stack past its depth, then empty it completely.
		set_rows(11'd2);
		flow = FLOW_BOTH;
		repeat (140) begin
			x = COORD_W'($urandom_range(1023));
			add_pixel(1'b1, x, 10'd0);
			add_pixel(1'($urandom_range(1)), x, 10'd1);
		end
		repeat (135) add_drain();
		wait_drained();

		rows_now = $urandom_range(2, 40);
		set_rows(ROWS_W'(rows_now));
		flow = FLOW_SINK_STALLS;
		while (scan_queue.size() < 150)
			add_random_unit(rows_now);
		wait_drained();

		if (fails == 0 && points_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
